/* rtl/ready_queue_scheduler_top_defines.svh */
// Assertion macros shared by the ready queue scheduler RTL.
`ifndef READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define RQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define RQS_NEVER(lbl, expr, msg) \
  `RQS_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/rqs_pkg.sv */
package rqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 10;
  localparam int TIME_W          = 16;
  localparam int SCORE_W         = 16;
  localparam int OCC_W           = 5;

  typedef enum logic [2:0] {
    KIND_ADD_TAIL  = 3'd0,
    KIND_ADD_HEAD  = 3'd1,
    KIND_SORTED    = 3'd2,
    KIND_POP_HEAD  = 3'd3,
    KIND_POP_SHORT = 3'd4,
    KIND_POP_ID    = 3'd5,
    KIND_AGE       = 3'd6,
    KIND_PEEK      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  run_time;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Verdict of the shared compare unit on one scanned entry.
  typedef struct packed {
    logic   sel;
    entry_t aged;
  } cmp_res_t;

endpackage

/* rtl/rqs_in_if.sv */
interface rqs_in_if import rqs_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [ID_W-1:0]    proc_id;
  logic [TIME_W-1:0]  run_time;
  logic [SCORE_W-1:0] age_score;

  modport source (output valid, kind, proc_id, run_time, age_score, input ready);
  modport sink   (input valid, kind, proc_id, run_time, age_score, output ready);
endinterface

/* rtl/rqs_out_if.sv */
interface rqs_out_if import rqs_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ID_W-1:0]    out_proc_id;
  logic [TIME_W-1:0]  out_run_time;
  logic [SCORE_W-1:0] out_age_score;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_proc_id, out_run_time, out_age_score,
                  occupancy, input ready);
  modport sink   (input valid, status, out_proc_id, out_run_time, out_age_score,
                  occupancy, output ready);
endinterface

/* rtl/ready_queue_scheduler_top.sv */
// Flow: a scan reads the entries (sorted insert, pops, peek, age), a shift moves entries
// to open or close a hole (inserts, pops), a put writes the new entry (inserts), and the
// result is then held until the sink takes it.
// Throughput: one request at a time; the entry memory (one read and one write port)
// paces the scan and the shift, one entry per cycle each.
// Reset (synchronous, rst_n low) empties the queue; the entry memory is not cleared.
`include "ready_queue_scheduler_top_defines.svh"

module ready_queue_scheduler_top import rqs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rqs_in_if.sink   in_chan,
  rqs_out_if.source out_chan
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // Sequencer state.
  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  entry_t           key_r, key_nxt;       // entry carried by the request
  entry_t           best_r, best_nxt;     // entry picked by the scan
  status_t          status_r, status_nxt;
  logic             show_r, show_nxt;     // result carries best_r
  logic             found_r, found_nxt;
  logic             vld_r, vld_nxt;       // read data arrives this cycle
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;       // next read index
  logic [CNT_W-1:0] vidx_r, vidx_nxt;     // index of the data now arriving
  logic [CNT_W-1:0] pos_r, pos_nxt;       // insert or remove position

  // Memory port.
  logic             mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
  entry_t           mem_wr_data, mem_rd_data;

  cmp_res_t         cmp_res;

  logic             full;
  logic             ins_kind;
  logic [CNT_W-1:0] scan_lim;
  logic [CNT_W-1:0] idx_m1, vidx_p1, vidx_m1, pos_p1;

  rqs_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // One compare unit serves every scan: sorted search, minimum, id match, aging.
  rqs_cmp u_cmp (
    .kind      (kind_r),
    .cur       (mem_rd_data),
    .key       (key_r),
    .first     (vidx_r == '0),
    .found     (found_r),
    .best_time (best_r.run_time),
    .res       (cmp_res)
  );

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign ins_kind = (kind_r == KIND_ADD_TAIL) || (kind_r == KIND_ADD_HEAD) ||
                    (kind_r == KIND_SORTED);
  // Head pop and peek only need the head entry.
  assign scan_lim = ((kind_r == KIND_POP_HEAD) || (kind_r == KIND_PEEK)) ?
                    CNT_W'(1) : count_r;
  assign idx_m1   = idx_r - CNT_W'(1);
  assign vidx_p1  = vidx_r + CNT_W'(1);
  assign vidx_m1  = vidx_r - CNT_W'(1);
  assign pos_p1   = pos_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    best_r   <= best_nxt;
    status_r <= status_nxt;
    show_r   <= show_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    vidx_r   <= vidx_nxt;
    pos_r    <= pos_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    best_nxt    = best_r;
    status_nxt  = status_r;
    show_nxt    = show_r;
    found_nxt   = found_r;
    vld_nxt     = 1'b0;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    vidx_nxt    = vidx_r;
    pos_nxt     = pos_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = vidx_r[IDX_W-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt   = in_chan.kind;
          key_nxt    = '{id: in_chan.proc_id, run_time: in_chan.run_time,
                         score: in_chan.age_score};
          status_nxt = STAT_OK;
          show_nxt   = 1'b0;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          case (in_chan.kind)
            KIND_ADD_TAIL,
            KIND_ADD_HEAD: begin
              if (full) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_RESP;
              end else begin
                // Tail add moves nothing; head add moves the whole queue.
                pos_nxt   = (in_chan.kind == KIND_ADD_TAIL) ? count_r : '0;
                idx_nxt   = count_r;
                state_nxt = S_SHIFT;
              end
            end
            KIND_SORTED: begin
              if (full) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = (in_chan.kind == KIND_AGE) ? STAT_OK : STAT_NOT_FOUND;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; judge the entry read last cycle.
        if (idx_r < scan_lim) begin
          mem_rd_en = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
          vld_nxt   = 1'b1;
          vidx_nxt  = idx_r;
        end
        if (vld_r) begin
          if (cmp_res.sel) begin
            found_nxt = 1'b1;
            pos_nxt   = vidx_r;
            best_nxt  = mem_rd_data;
          end
          if (kind_r == KIND_AGE) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = cmp_res.aged;
          end
        end
        if (!vld_r && !(idx_r < scan_lim)) begin
          case (kind_r)
            KIND_SORTED: begin
              // No greater score: append at the tail.
              if (!found_r) begin
                pos_nxt = count_r;
              end
              idx_nxt   = count_r;
              state_nxt = S_SHIFT;
            end
            KIND_POP_HEAD,
            KIND_POP_SHORT,
            KIND_POP_ID: begin
              if (found_r) begin
                show_nxt  = 1'b1;
                idx_nxt   = pos_p1;
                state_nxt = S_SHIFT;
              end else begin
                status_nxt = STAT_NOT_FOUND;
                state_nxt  = S_RESP;
              end
            end
            KIND_PEEK: begin
              show_nxt  = 1'b1;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (ins_kind) begin
          // Open a hole at pos_r: move entries up, last one first.
          if (idx_r > pos_r) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_m1[IDX_W-1:0];
            idx_nxt     = idx_m1;
            vld_nxt     = 1'b1;
            vidx_nxt    = idx_m1;
          end
          if (vld_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = vidx_p1[IDX_W-1:0];
          end
          if (!vld_r && !(idx_r > pos_r)) begin
            state_nxt = S_PUT;
          end
        end else begin
          // Close the hole at pos_r: move entries down, first one first.
          if (idx_r < count_r) begin
            mem_rd_en = 1'b1;
            idx_nxt   = idx_r + CNT_W'(1);
            vld_nxt   = 1'b1;
            vidx_nxt  = idx_r;
          end
          if (vld_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = vidx_m1[IDX_W-1:0];
          end
          if (!vld_r && !(idx_r < count_r)) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end
        end
      end

      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r[IDX_W-1:0];
        mem_wr_data = key_r;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        // Hold the result until the sink takes it.
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = (state_r == S_RESP);
  assign out_chan.status        = status_r;
  assign out_chan.out_proc_id   = show_r ? best_r.id       : '0;
  assign out_chan.out_run_time  = show_r ? best_r.run_time : '0;
  assign out_chan.out_age_score = show_r ? best_r.score    : '0;
  assign out_chan.occupancy     = OCC_W'(count_r);

  `RQS_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
  `RQS_ASSERT(a_one_request, out_chan.valid |-> !in_chan.ready,
              "request accepted while a result is pending")
  `RQS_ASSERT(a_full_refusal, (state_r == S_RESP && status_r == STAT_FULL) |-> full,
              "full status with free space")
  `RQS_ASSERT(a_count_stable,
              (state_r == S_IDLE || state_r == S_SCAN || state_r == S_RESP) |=>
              $stable(count_r), "occupancy changed outside shift or put")
  `RQS_NEVER(a_wr_range, mem_wr_en && (CNT_W'(mem_wr_addr) > count_r),
             "entry write beyond the queue tail")

endmodule

/* rtl/rqs_mem.sv */
module rqs_mem import rqs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rqs_cmp.sv */
module rqs_cmp import rqs_pkg::*; (
  input  kind_t             kind,
  input  entry_t            cur,
  input  entry_t            key,
  input  logic              first,
  input  logic              found,
  input  logic [TIME_W-1:0] best_time,
  output cmp_res_t          res
);

  always_comb begin
    res.aged       = cur;
    res.aged.score = cur.score - SCORE_W'(cur.score != '0);
    case (kind)
      KIND_SORTED:    res.sel = !found && (cur.score > key.score);
      KIND_POP_HEAD,
      KIND_PEEK:      res.sel = first;
      KIND_POP_SHORT: res.sel = first || (cur.run_time < best_time);
      KIND_POP_ID:    res.sel = !found && (cur.id == key.id);
      default:        res.sel = 1'b0;
    endcase
  end

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rqs_pkg::*;

  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_OPS   = 1850;
  // Worst case is a full scan plus a full shift, with some margin on top.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

  // One scheduler request as it crosses the input channel.
  typedef struct {
    kind_t              kind;
    logic [ID_W-1:0]    proc_id;
    logic [TIME_W-1:0]  run_time;
    logic [SCORE_W-1:0] age_score;
  } sched_req_t;

  // One scheduler response as it should appear on the output channel.
  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    proc_id;
    logic [TIME_W-1:0]  run_time;
    logic [SCORE_W-1:0] age_score;
    logic [OCC_W-1:0]   occupancy;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  rqs_in_if  sched_req ();
  rqs_out_if sched_rsp ();

  ready_queue_scheduler_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (sched_req.sink),
    .out_chan (sched_rsp.source)
  );

  // Requests still to be driven, filled up front by the stimulus block.
  sched_req_t pending_ops[$];
  // Shadow copy of the ready queue, head at index 0.
  entry_t     ready_model[$];
  // Responses predicted for accepted requests, oldest first.
  sched_rsp_t predicted_rsp[$];

  int accepted_ops = 0;
  int error_count  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hold both sides free of idling over one stretch of requests.
  function automatic bit steady_stretch();
    return accepted_ops >= 700 && accepted_ops < 1100;
  endfunction

  // Apply one accepted request to the shadow queue and queue its response.
  function automatic void apply_sched_op(input sched_req_t op);
    sched_rsp_t rsp;
    entry_t     ent;
    int         pos;
    int         take_pos;
    rsp.status    = STAT_OK;
    rsp.proc_id   = '0;
    rsp.run_time  = '0;
    rsp.age_score = '0;
    ent.id        = op.proc_id;
    ent.run_time  = op.run_time;
    ent.score     = op.age_score;
    take_pos      = -1;
    case (op.kind)
      KIND_ADD_TAIL, KIND_ADD_HEAD, KIND_SORTED: begin
        if (ready_model.size() >= DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          pos = ready_model.size();
          if (op.kind == KIND_ADD_HEAD) begin
            pos = 0;
          end else if (op.kind == KIND_SORTED) begin
            // Land before the first entry whose score is greater.
            for (int i = 0; i < ready_model.size(); i++) begin
              if (ready_model[i].score > op.age_score) begin
                pos = i;
                break;
              end
            end
          end
          ready_model.insert(pos, ent);
        end
      end
      KIND_POP_HEAD, KIND_PEEK: begin
        if (ready_model.size() == 0) begin
          rsp.status = STAT_NOT_FOUND;
        end else if (op.kind == KIND_POP_HEAD) begin
          take_pos = 0;
        end else begin
          rsp.proc_id   = ready_model[0].id;
          rsp.run_time  = ready_model[0].run_time;
          rsp.age_score = ready_model[0].score;
        end
      end
      KIND_POP_SHORT: begin
        if (ready_model.size() == 0) begin
          rsp.status = STAT_NOT_FOUND;
        end else begin
          // Strict compare keeps the entry nearest the head on a tie.
          take_pos = 0;
          for (int i = 1; i < ready_model.size(); i++) begin
            if (ready_model[i].run_time < ready_model[take_pos].run_time) take_pos = i;
          end
        end
      end
      KIND_POP_ID: begin
        for (int i = 0; i < ready_model.size(); i++) begin
          if (ready_model[i].id == op.proc_id) begin
            take_pos = i;
            break;
          end
        end
        if (take_pos < 0) rsp.status = STAT_NOT_FOUND;
      end
      default: begin
        // Age: decrement every score, saturating at zero.
        foreach (ready_model[i]) begin
          if (ready_model[i].score != '0) ready_model[i].score = ready_model[i].score - 1'b1;
        end
      end
    endcase
    if (take_pos >= 0) begin
      rsp.proc_id   = ready_model[take_pos].id;
      rsp.run_time  = ready_model[take_pos].run_time;
      rsp.age_score = ready_model[take_pos].score;
      ready_model.delete(take_pos);
    end
    rsp.occupancy = OCC_W'(ready_model.size());
    predicted_rsp.push_back(rsp);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      error_count++;
    end
  endfunction

  // Driver: advance to the next pending request once the current one is taken,
  // idling at random outside the steady stretch.
  always @(posedge clk) begin : req_driver
    sched_req_t nxt;
    if (!rst_n) begin
      sched_req.valid <= 1'b0;
    end else if (!sched_req.valid || sched_req.ready) begin
      if (pending_ops.size() != 0 && (steady_stretch() || $urandom_range(99) >= 14)) begin
        nxt = pending_ops.pop_front();
        sched_req.valid     <= 1'b1;
        sched_req.kind      <= nxt.kind;
        sched_req.proc_id   <= nxt.proc_id;
        sched_req.run_time  <= nxt.run_time;
        sched_req.age_score <= nxt.age_score;
      end else begin
        sched_req.valid <= 1'b0;
      end
    end
  end

  // Monitor: check responses first, then predict from the request taken at
  // this edge, so both queue updates happen in one process in a fixed order.
  always @(posedge clk) begin : rsp_monitor
    sched_rsp_t exp_rsp;
    sched_req_t seen;
    if (!rst_n) begin
      sched_rsp.ready <= 1'b0;
    end else begin
      if (sched_rsp.valid && sched_rsp.ready) begin
        if (predicted_rsp.size() == 0) begin
          $error("response with no request outstanding: status %0d occupancy %0d",
                 sched_rsp.status, sched_rsp.occupancy);
          error_count++;
        end else begin
          exp_rsp = predicted_rsp.pop_front();
          check_field("status", exp_rsp.status, sched_rsp.status);
          check_field("out_proc_id", exp_rsp.proc_id, sched_rsp.out_proc_id);
          check_field("out_run_time", exp_rsp.run_time, sched_rsp.out_run_time);
          check_field("out_age_score", exp_rsp.age_score, sched_rsp.out_age_score);
          check_field("occupancy", exp_rsp.occupancy, sched_rsp.occupancy);
        end
      end
      if (sched_req.valid && sched_req.ready) begin
        seen.kind      = sched_req.kind;
        seen.proc_id   = sched_req.proc_id;
        seen.run_time  = sched_req.run_time;
        seen.age_score = sched_req.age_score;
        apply_sched_op(seen);
        accepted_ops <= accepted_ops + 1;
      end
      sched_rsp.ready <= steady_stretch() || $urandom_range(99) >= 14;
    end
  end

  function automatic void push_op(input kind_t kind, input int unsigned id,
                                  input int unsigned run_time, input int unsigned score);
    sched_req_t op;
    op.kind      = kind;
    op.proc_id   = ID_W'(id);
    op.run_time  = TIME_W'(run_time);
    op.age_score = SCORE_W'(score);
    pending_ops.push_back(op);
  endfunction

  // Mix of tiny values for ties, the two extremes, and the full range.
  function automatic int unsigned pick_word();
    case ($urandom_range(3))
      0:       return $urandom_range(7);
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  // Mostly a small id pool so pop by id finds its target.
  function automatic int unsigned pick_id();
    if ($urandom_range(99) < 75) return $urandom_range(15);
    return $urandom_range(10'h3FF);
  endfunction

  initial begin : stimulus
    int    mode;
    int    roll;
    int    made;
    kind_t kind;
    sched_req.valid     = 1'b0;
    sched_req.kind      = KIND_ADD_TAIL;
    sched_req.proc_id   = '0;
    sched_req.run_time  = '0;
    sched_req.age_score = '0;
    sched_rsp.ready     = 1'b0;
    rst_n               = 1'b0;

    // Every removing or reading kind on an empty queue.
    push_op(KIND_PEEK, 0, 0, 0);
    push_op(KIND_POP_HEAD, 0, 0, 0);
    push_op(KIND_POP_SHORT, 0, 0, 0);
    push_op(KIND_POP_ID, 10'h3FF, 0, 0);
    push_op(KIND_AGE, 0, 0, 0);
    // Field extremes, then sorted inserts with ties and a score between two others.
    push_op(KIND_ADD_TAIL, 10'h3FF, 16'hFFFF, 16'hFFFF);
    push_op(KIND_ADD_HEAD, 0, 0, 0);
    push_op(KIND_SORTED, 5, 100, 16'hFFFF);
    push_op(KIND_SORTED, 6, 100, 0);
    push_op(KIND_SORTED, 7, 3, 1);
    push_op(KIND_ADD_TAIL, 8, 0, 9);
    // Age a queue holding zero, one and maximum scores.
    push_op(KIND_AGE, 0, 0, 0);
    push_op(KIND_PEEK, 0, 0, 0);
    // Shortest pop with two zero job times: the one nearer the head goes.
    push_op(KIND_POP_SHORT, 0, 0, 0);
    push_op(KIND_POP_ID, 999, 0, 0);
    push_op(KIND_POP_ID, 5, 0, 0);
    push_op(KIND_POP_HEAD, 0, 0, 0);
    push_op(KIND_POP_SHORT, 0, 0, 0);
    push_op(KIND_ADD_TAIL, 10'h2AA, 16'h5555, 16'hAAAA);
    push_op(KIND_ADD_HEAD, 10'h155, 16'hAAAA, 16'h5555);
    push_op(KIND_SORTED, 10'h2AA, 16'h5555, 16'h5555);
    push_op(KIND_PEEK, 0, 0, 0);

    // Random phases: fill pushes the queue to full and into refused inserts,
    // drain empties it, mixed picks any kind.
    made = 0;
    while (made < RANDOM_OPS) begin
      mode = $urandom_range(2);
      repeat ($urandom_range(20, 60)) begin
        roll = $urandom_range(99);
        case (mode)
          0:       kind = (roll < 70) ? kind_t'($urandom_range(2)) : kind_t'($urandom_range(7));
          1:       kind = (roll < 70) ? kind_t'($urandom_range(5, 3)) : kind_t'($urandom_range(7));
          default: kind = kind_t'($urandom_range(7));
        endcase
        push_op(kind, pick_id(), pick_word(), pick_word());
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the loop never races the edge updates.
    while (pending_ops.size() != 0 || sched_req.valid) @(negedge clk);
    while (predicted_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rqs_pkg.sv
rtl/rqs_in_if.sv
rtl/rqs_out_if.sv
rtl/rqs_mem.sv
rtl/rqs_cmp.sv
rtl/ready_queue_scheduler_top.sv
sim/testbench.sv
